>>> rtl/core/m4v4t_pkg.sv
// Shared constants and types for the 4x4 matrix by 4-vector transform.
// No dependencies; compiled first.
package m4v4t_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int COEF_WIDTH     = 16;
  localparam int NUM_ROWS       = 4;
  localparam int ROW_WIDTH      = NUM_ROWS * COEF_WIDTH;
  localparam int ROW_IDX_W      = $clog2(NUM_ROWS);
  localparam int CFG_IDX_W      = 8;
  localparam int PROD_W         = DATA_WIDTH + COEF_WIDTH;
  localparam int SUM_W          = PROD_W + ROW_IDX_W;

  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef logic [NUM_ROWS-1:0][ROW_WIDTH-1:0]  m4v4t_mat_t;
  typedef logic [NUM_ROWS-1:0][COEF_WIDTH-1:0] m4v4t_col_t;
  typedef logic [NUM_ROWS-1:0][DATA_WIDTH-1:0] m4v4t_vec_t;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } m4v4t_lane_ctl_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  clip;
  } m4v4t_lane_res_t;

  typedef m4v4t_lane_res_t [NUM_ROWS-1:0] m4v4t_lane_bus_t;

endpackage

>>> rtl/core/m4v4t_ifs.sv
// Handshake channels: vector input, transformed result, register write.
// Depends on m4v4t_pkg.
interface m4v4t_vec_if import m4v4t_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] comp_x;
  logic signed [DATA_WIDTH-1:0] comp_y;
  logic signed [DATA_WIDTH-1:0] comp_z;
  logic signed [DATA_WIDTH-1:0] comp_w;
  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface m4v4t_res_if import m4v4t_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic signed [DATA_WIDTH-1:0] out_w;
  logic                         saturated;
  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

interface m4v4t_cfg_if import m4v4t_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ROW_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mat4_vec4_transform.sv
// Row-vector by 4x4 matrix transform, four column lanes and a merging output register.
// Registered stages in order: products, sum and clip, output.
// Throughput: one beat per cycle unless the output stalls, set by the four lanes of four multipliers each.
// Stages advance independently, so input is taken while a result waits.
// Reset (rst_n low, synchronous): pipeline emptied, matrix loaded with identity.
// Depends on m4v4t_pkg, m4v4t_ifs, m4v4t_cfg_regs, m4v4t_lane and m4v4t_merge.
module mat4_vec4_transform import m4v4t_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  m4v4t_vec_if.sink   in_vec,
  m4v4t_res_if.source out_res,
  m4v4t_cfg_if.sink   cfg_wr
);

  m4v4t_mat_t      mat;
  m4v4t_vec_t      vec;
  m4v4t_col_t      cols [NUM_ROWS];
  m4v4t_lane_ctl_t ctl;
  m4v4t_lane_bus_t lanes;
  logic            take;
  logic            mul_v_r;
  logic            sum_v_r;
  logic            in_take;

  m4v4t_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .mat    (mat)
  );

  assign vec[0] = in_vec.comp_x;
  assign vec[1] = in_vec.comp_y;
  assign vec[2] = in_vec.comp_z;
  assign vec[3] = in_vec.comp_w;

  always_comb begin
    for (int j = 0; j < NUM_ROWS; j++) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        cols[j][i] = mat[i][j*COEF_WIDTH +: COEF_WIDTH];
      end
    end
  end

  assign ctl.en_sum   = ~sum_v_r | take;
  assign ctl.en_mul   = ~mul_v_r | ctl.en_sum;
  assign in_take      = ctl.en_mul;
  assign in_vec.ready = in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      sum_v_r <= 1'b0;
    end else begin
      if (ctl.en_mul) begin
        mul_v_r <= in_vec.valid;
      end
      if (ctl.en_sum) begin
        sum_v_r <= mul_v_r;
      end
    end
  end

  for (genvar j = 0; j < NUM_ROWS; j++) begin : g_lane
    m4v4t_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .vec (vec),
      .col (cols[j]),
      .res (lanes[j])
    );
  end

  m4v4t_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .lanes_valid (sum_v_r),
    .lanes       (lanes),
    .take        (take),
    .out_res     (out_res)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vec.valid && in_vec.ready) |=> mul_v_r)
    else $error("accepted beat did not enter the product stage");

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_v_r && !take) |=> (sum_v_r && $stable(lanes)))
    else $error("lane result lost while output stalled");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(sum_v_r))
    else $error("result appeared without a lane result");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.saturated) |->
      (out_res.out_x == $signed(DATA_MAX) || out_res.out_x == $signed(DATA_MIN) ||
       out_res.out_y == $signed(DATA_MAX) || out_res.out_y == $signed(DATA_MIN) ||
       out_res.out_z == $signed(DATA_MAX) || out_res.out_z == $signed(DATA_MIN) ||
       out_res.out_w == $signed(DATA_MAX) || out_res.out_w == $signed(DATA_MIN)))
    else $error("saturated flag set with no clipped component");

endmodule

>>> rtl/core/m4v4t_cfg_regs.sv
// Matrix row registers, reset to identity; writes beyond the last row dropped.
// Depends on m4v4t_pkg and m4v4t_cfg_if.
module m4v4t_cfg_regs import m4v4t_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  m4v4t_cfg_if.sink   cfg_wr,
  output m4v4t_mat_t  mat
);

  m4v4t_mat_t rows_r;

  assign cfg_wr.ready = 1'b1;
  assign mat          = rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        rows_r[r] <= ROW_WIDTH'(COEF_ONE) << (r * COEF_WIDTH);
      end
    end else if (cfg_wr.valid && (cfg_wr.index < CFG_IDX_W'(NUM_ROWS))) begin
      rows_r[cfg_wr.index[ROW_IDX_W-1:0]] <= cfg_wr.data;
    end
  end

endmodule

>>> rtl/core/m4v4t_lane.sv
// One output column: four registered products, then sum, floor shift, clip.
// Depends on m4v4t_pkg.
module m4v4t_lane import m4v4t_pkg::*; (
  input  logic            clk,
  input  m4v4t_lane_ctl_t ctl,
  input  m4v4t_vec_t      vec,
  input  m4v4t_col_t      col,
  output m4v4t_lane_res_t res
);

  localparam int HI_W = SUM_W - COEF_FRAC_BITS - DATA_WIDTH + 1;

  logic signed [PROD_W-1:0] prod_r [NUM_ROWS];
  logic signed [SUM_W-1:0]  sum;
  logic [HI_W-1:0]          hi;
  logic                     in_range;
  m4v4t_lane_res_t          res_nxt;
  m4v4t_lane_res_t          res_r;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        prod_r[i] <= $signed(vec[i]) * $signed(col[i]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      sum = sum + SUM_W'(prod_r[i]);
    end
    hi       = sum[SUM_W-1 -: HI_W];
    in_range = (&hi) | ~(|hi);
    if (in_range) begin
      res_nxt.value = sum[COEF_FRAC_BITS +: DATA_WIDTH];
    end else if (sum[SUM_W-1]) begin
      res_nxt.value = DATA_MIN;
    end else begin
      res_nxt.value = DATA_MAX;
    end
    res_nxt.clip = ~in_range;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> rtl/core/m4v4t_merge.sv
// Output register: gathers the four lane results and ORs their clip flags.
// Depends on m4v4t_pkg and m4v4t_res_if.
module m4v4t_merge import m4v4t_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            lanes_valid,
  input  m4v4t_lane_bus_t lanes,
  output logic            take,
  m4v4t_res_if.source     out_res
);

  logic                  out_v_r;
  logic [DATA_WIDTH-1:0] x_r, y_r, z_r, w_r;
  logic                  sat_r;
  logic                  sat_nxt;

  assign take = ~out_v_r | out_res.ready;

  always_comb begin
    sat_nxt = 1'b0;
    for (int j = 0; j < NUM_ROWS; j++) begin
      sat_nxt = sat_nxt | lanes[j].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take) begin
      out_v_r <= lanes_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lanes_valid) begin
      x_r   <= lanes[0].value;
      y_r   <= lanes[1].value;
      z_r   <= lanes[2].value;
      w_r   <= lanes[3].value;
      sat_r <= sat_nxt;
    end
  end

  assign out_res.valid     = out_v_r;
  assign out_res.out_x     = $signed(x_r);
  assign out_res.out_y     = $signed(y_r);
  assign out_res.out_z     = $signed(z_r);
  assign out_res.out_w     = $signed(w_r);
  assign out_res.saturated = sat_r;

endmodule
